// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the easing curve evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/bec_pkg.sv =====
// Package with the word types and constants of the easing curve evaluator.
package bec_pkg;

   localparam int MAX_ITERATIONS_DEF = 24;
   localparam int FRACTION_BITS_DEF  = 24;

   localparam int TOL_WIDTH = 16;
   localparam logic [TOL_WIDTH-1:0] TOLERANCE_RESET = 16'd1678;

   typedef struct packed {
      logic [15:0] progress;
      logic [7:0]  x_control_a;
      logic [7:0]  y_control_a;
      logic [7:0]  x_control_b;
      logic [7:0]  y_control_b;
   } req_word_type;

   typedef struct packed {
      logic [16:0] eased_value;
      logic        limit_hit;
   } rsp_word_type;

endpackage

// ===== rtl/bec_lerp_unit.sv =====
// Shared interpolation unit computing a + (b - a) * s in unsigned fixed point.
module bec_lerp_unit #(
   parameter int FRACTION_BITS = 24
) (
   input  logic [FRACTION_BITS:0] a,
   input  logic [FRACTION_BITS:0] b,
   input  logic [FRACTION_BITS:0] s,
   output logic [FRACTION_BITS:0] y
);

   localparam int W = FRACTION_BITS + 1;
   localparam logic [W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   logic          rising;
   logic [W-1:0]  mag;
   logic [2*W-1:0] prod;
   logic [W-1:0]  scaled;

   always_comb begin
      rising = (b >= a);
      mag    = rising ? (b - a) : (a - b);
      prod   = mag * s;
      if (s >= ONE) begin
         scaled = mag;
      end else begin
         scaled = prod[FRACTION_BITS +: W];
      end
      y = rising ? (a + scaled) : (a - scaled);
   end

endmodule

// ===== rtl/bec_ctrl.sv =====
// Sequencer running the bisection and the de Casteljau steps on the shared unit.
`include "assert_macros.svh"

module bec_ctrl #(
   parameter int MAX_ITERATIONS = 24,
   parameter int FRACTION_BITS  = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bec_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bec_pkg::rsp_word_type rsp_word,
   input  logic [bec_pkg::TOL_WIDTH-1:0] tolerance
);

   import bec_pkg::*;

   localparam int W  = FRACTION_BITS + 1;
   localparam int IW = $clog2(MAX_ITERATIONS + 1);
   localparam logic [W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   typedef enum logic [1:0] {IDLE, X_EVAL, Y_EVAL, FINISH} state_type;
   typedef enum logic [2:0] {
      STEP_P01, STEP_P12, STEP_P23, STEP_Q0, STEP_Q1, STEP_R, STEP_TEST
   } step_type;

   state_type    state_ff, state_in;
   step_type     step_ff, step_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic         done_ff, done_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic [W-1:0] t_ff, t_in;
   logic [7:0]   xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic [W-1:0] low_ff, low_in, high_ff, high_in, s_ff, s_in;
   logic [W-1:0] p01_ff, p01_in, p12_ff, p12_in, p23_ff, p23_in;
   logic [W-1:0] q0_ff, q0_in, q1_ff, q1_in, r_ff, r_in;

   logic [W-1:0] op_a, op_b, lerp_q;
   logic [W-1:0] c1, c2, diff, new_low, new_high;
   logic [W:0]   mid_sum;
   logic         x_below, hit, accept;

   function automatic logic [W-1:0] coord(input logic [7:0] c);
      coord = W'(c) << (FRACTION_BITS - 8);
   endfunction

   bec_lerp_unit #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_lerp (
      .a(op_a),
      .b(op_b),
      .s(s_ff),
      .y(lerp_q)
   );

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      c1 = (state_ff == Y_EVAL) ? coord(ya_ff) : coord(xa_ff);
      c2 = (state_ff == Y_EVAL) ? coord(yb_ff) : coord(xb_ff);
      case (step_ff)
         STEP_P01: begin op_a = '0;     op_b = c1;     end
         STEP_P12: begin op_a = c1;     op_b = c2;     end
         STEP_P23: begin op_a = c2;     op_b = ONE;    end
         STEP_Q0:  begin op_a = p01_ff; op_b = p12_ff; end
         STEP_Q1:  begin op_a = p12_ff; op_b = p23_ff; end
         STEP_R:   begin op_a = q0_ff;  op_b = q1_ff;  end
         default:  begin op_a = '0;     op_b = '0;     end
      endcase

      diff     = (r_ff >= t_ff) ? (r_ff - t_ff) : (t_ff - r_ff);
      hit      = (diff < W'(tolerance));
      x_below  = (r_ff < t_ff);
      new_low  = x_below ? s_ff : low_ff;
      new_high = x_below ? high_ff : s_ff;
      mid_sum  = {1'b0, new_low} + {1'b0, new_high};
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      t_in   = t_ff;
      xa_in  = xa_ff;
      ya_in  = ya_ff;
      xb_in  = xb_ff;
      yb_in  = yb_ff;
      low_in = low_ff;
      high_in = high_ff;
      s_in   = s_ff;
      p01_in = p01_ff;
      p12_in = p12_ff;
      p23_in = p23_ff;
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      r_in   = r_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (step_ff)
         STEP_P01: p01_in = lerp_q;
         STEP_P12: p12_in = lerp_q;
         STEP_P23: p23_in = lerp_q;
         STEP_Q0:  q0_in  = lerp_q;
         STEP_Q1:  q1_in  = lerp_q;
         STEP_R:   r_in   = lerp_q;
         default:  r_in   = r_ff;
      endcase

      case (state_ff)
         IDLE: begin
            step_in = STEP_P01;
            if (accept) begin
               t_in    = W'(req_word.progress) << (FRACTION_BITS - 16);
               xa_in   = req_word.x_control_a;
               ya_in   = req_word.y_control_a;
               xb_in   = req_word.x_control_b;
               yb_in   = req_word.y_control_b;
               low_in  = '0;
               high_in = ONE;
               s_in    = W'(req_word.progress) << (FRACTION_BITS - 16);
               iter_in = '0;
               state_in = X_EVAL;
            end
         end
         X_EVAL: begin
            case (step_ff)
               STEP_P01: step_in = STEP_P12;
               STEP_P12: step_in = STEP_P23;
               STEP_P23: step_in = STEP_Q0;
               STEP_Q0:  step_in = STEP_Q1;
               STEP_Q1:  step_in = STEP_R;
               STEP_R:   step_in = STEP_TEST;
               default: begin
                  step_in = STEP_P01;
                  if (hit) begin
                     done_in  = 1'b1;
                     state_in = Y_EVAL;
                  end else begin
                     low_in  = new_low;
                     high_in = new_high;
                     s_in    = mid_sum[W:1];
                     iter_in = IW'(iter_ff + 1'b1);
                     if (IW'(iter_ff + 1'b1) == IW'(MAX_ITERATIONS)) begin
                        done_in  = 1'b0;
                        state_in = Y_EVAL;
                     end
                  end
               end
            endcase
         end
         Y_EVAL: begin
            case (step_ff)
               STEP_P01: step_in = STEP_P12;
               STEP_P12: step_in = STEP_P23;
               STEP_P23: step_in = STEP_Q0;
               STEP_Q0:  step_in = STEP_Q1;
               STEP_Q1:  step_in = STEP_R;
               default: begin
                  step_in  = STEP_TEST;
                  state_in = FINISH;
               end
            endcase
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_word_in.eased_value = r_ff[FRACTION_BITS -: 17];
               rsp_word_in.limit_hit   = !done_ff;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= STEP_P01;
         iter_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      t_ff    <= t_in;
      xa_ff   <= xa_in;
      ya_ff   <= ya_in;
      xb_ff   <= xb_in;
      yb_ff   <= yb_in;
      low_ff  <= low_in;
      high_ff <= high_in;
      s_ff    <= s_in;
      p01_ff  <= p01_in;
      p12_ff  <= p12_in;
      p23_ff  <= p23_in;
      q0_ff   <= q0_in;
      q1_ff   <= q1_in;
      r_ff    <= r_in;
   end

   `ASSERT_ALWAYS(a_iter_bound, clock, reset, iter_ff <= IW'(MAX_ITERATIONS))
   `ASSERT_IMPLIES(a_bracket, clock, reset, state_ff == X_EVAL, (low_ff <= s_ff) && (s_ff <= high_ff) && (high_ff <= ONE))
   `ASSERT_NEXT(a_start, clock, reset, accept, (state_ff == X_EVAL) && (step_ff == STEP_P01) && (iter_ff == '0))

endmodule

// ===== rtl/bezier_easing_curve_eval_core.sv =====
// Top level of the cubic Bezier easing curve evaluator with its tolerance register.
//
//   Port group  Direction  Contents
//   req_        in         progress and the two control points, valid/ready
//   rsp_        out        eased value and cap flag, valid/ready
//   csr_        in         tolerance write, no handshake
//
// Each bisection step runs six passes through the shared interpolation unit and
// one compare step; after at most MAX_ITERATIONS steps the final y evaluation
// runs the six passes once more.
// The block takes a new word only when idle; a result waiting on rsp_ready
// holds the finished item back until the output register is free.
// Reset is synchronous and sets the tolerance to its default.
module bezier_easing_curve_eval_core #(
   parameter int MAX_ITERATIONS = bec_pkg::MAX_ITERATIONS_DEF,
   parameter int FRACTION_BITS  = bec_pkg::FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bec_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bec_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_en,
   input  logic [bec_pkg::TOL_WIDTH-1:0] csr_write_data
);

   import bec_pkg::*;

   logic [TOL_WIDTH-1:0] tolerance_ff, tolerance_in;

   assign tolerance_in = csr_write_en ? csr_write_data : tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOLERANCE_RESET;
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   bec_ctrl #(
      .MAX_ITERATIONS(MAX_ITERATIONS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .tolerance(tolerance_ff)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the Bezier easing curve evaluator with handshake stalls.
`timescale 1ns / 100ps

module tb_top;
   import bec_pkg::*;

   localparam int FB = FRACTION_BITS_DEF;
   localparam int ITER_CAP = MAX_ITERATIONS_DEF;
   localparam int SETTLE_CYCLES = 7 * MAX_ITERATIONS_DEF + 16;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int PHASE_WORDS = 150;

   typedef logic [63:0] fixq_t;
   localparam fixq_t UNIT = fixq_t'(1) << FB;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_write_en = 1'b0;
   logic [TOL_WIDTH-1:0] csr_write_data = '0;

   req_word_type curve_words_q[$];
   rsp_word_type eased_results_q[$];
   rsp_word_type due_word;
   logic [TOL_WIDTH-1:0] tol_model = TOLERANCE_RESET;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;
   int req_gap = 0;
   int rsp_wait = 0;
   int hold_left = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int failures = 0;

   bezier_easing_curve_eval_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic fixq_t scaled_product(fixq_t u, fixq_t s);
      if (s >= UNIT) return u;
      return (u * s) >> FB;
   endfunction

   function automatic fixq_t blend(fixq_t a, fixq_t b, fixq_t s);
      if (b >= a) return a + scaled_product(b - a, s);
      return a - scaled_product(a - b, s);
   endfunction

   function automatic fixq_t curve_coord(fixq_t c1, fixq_t c2, fixq_t s);
      fixq_t p01, p12, p23, q0, q1;
      p01 = blend('0, c1, s);
      p12 = blend(c1, c2, s);
      p23 = blend(c2, UNIT, s);
      q0 = blend(p01, p12, s);
      q1 = blend(p12, p23, s);
      return blend(q0, q1, s);
   endfunction

   function automatic rsp_word_type ease_lookup(req_word_type w, logic [TOL_WIDTH-1:0] tol);
      fixq_t t, xa, ya, xb, yb, lo, hi, s, x, x_gap, y;
      bit settled;
      rsp_word_type r;
      t = fixq_t'(w.progress) << (FB - 16);
      xa = fixq_t'(w.x_control_a) << (FB - 8);
      ya = fixq_t'(w.y_control_a) << (FB - 8);
      xb = fixq_t'(w.x_control_b) << (FB - 8);
      yb = fixq_t'(w.y_control_b) << (FB - 8);
      lo = '0;
      hi = UNIT;
      s = t;
      settled = 1'b0;
      for (int i = 0; i < ITER_CAP && !settled; i++) begin
         x = curve_coord(xa, xb, s);
         x_gap = (x >= t) ? x - t : t - x;
         if (x_gap < fixq_t'(tol)) begin
            settled = 1'b1;
         end else begin
            if (x < t) lo = s;
            else hi = s;
            s = (lo + hi) >> 1;
         end
      end
      y = curve_coord(ya, yb, s);
      r.eased_value = 17'(y >> (FB - 16));
      r.limit_hit = !settled;
      return r;
   endfunction

   function automatic req_word_type curve_word(logic [15:0] p, logic [7:0] xa, logic [7:0] ya,
                                               logic [7:0] xb, logic [7:0] yb);
      req_word_type w;
      w.progress = p;
      w.x_control_a = xa;
      w.y_control_a = ya;
      w.x_control_b = xb;
      w.y_control_b = yb;
      return w;
   endfunction

   function automatic logic [7:0] edgy_coord();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_word_type random_curve_word();
      req_word_type w;
      logic [15:0] p;
      p = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
         0: w = curve_word(p, 8'd64, 8'd26, 8'd64, 8'd255);
         1: w = curve_word(p, 8'd107, 8'd0, 8'd255, 8'd255);
         2: w = curve_word(p, 8'd0, 8'd0, 8'd148, 8'd255);
         3: begin
            case ($urandom_range(0, 3))
               0: p = 16'd0;
               1: p = 16'hFFFF;
               2: p = 16'd1;
               default: p = p;
            endcase
            w = curve_word(p, edgy_coord(), edgy_coord(), edgy_coord(), edgy_coord());
         end
         default: w = curve_word(p, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      return w;
   endfunction

   task automatic queue_word(input req_word_type w);
      curve_words_q = {curve_words_q, w};
   endtask

   task automatic write_tolerance(input logic [TOL_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      tol_model = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (curve_words_q.size() != 0 || req_valid || eased_results_q.size() != 0)
         @(posedge clock);
   endtask

   // Sender: offers queued words, with a drawn gap after each accepted word.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_taken) begin
         if (req_taken) req_gap = sender_steady ? 0 : $urandom_range(0, 7);
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (curve_words_q.size() > 0) begin
            req_word <= curve_words_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls for a drawn number of cycles after each word, or for a long hold.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
         hold_left = 0;
      end else begin
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (rsp_taken) rsp_wait = receiver_steady ? 0 : $urandom_range(0, 7);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (req_valid && req_ready)
            eased_results_q = {eased_results_q, ease_lookup(req_word, tol_model)};
         if (rsp_valid && rsp_ready) begin
            if (eased_results_q.size() == 0) begin
               failures++;
               $display("%0t: unexpected word, expected none, actual eased_value=%0d limit_hit=%0d",
                        $time, rsp_word.eased_value, rsp_word.limit_hit);
            end else begin
               due_word = eased_results_q.pop_front();
               if (rsp_word.eased_value !== due_word.eased_value) begin
                  failures++;
                  $display("%0t: eased_value mismatch, expected %0d, actual %0d",
                           $time, due_word.eased_value, rsp_word.eased_value);
               end
               if (rsp_word.limit_hit !== due_word.limit_hit) begin
                  failures++;
                  $display("%0t: limit_hit mismatch, expected %0d, actual %0d",
                           $time, due_word.limit_hit, rsp_word.limit_hit);
               end
            end
         end
      end
   end

   initial begin
      logic [TOL_WIDTH-1:0] tol_plan[11];
      tol_plan = '{16'd1, 16'hFFFF, 16'd0, TOLERANCE_RESET, 16'($urandom_range(1, 65535)),
                   16'd2, 16'($urandom_range(1, 4000)), 16'hFFFE,
                   16'($urandom_range(1, 65535)), 16'd1, 16'($urandom_range(1, 400))};
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset tolerance.
      queue_word(curve_word(16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      queue_word(curve_word(16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255));
      queue_word(curve_word(16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0));
      queue_word(curve_word(16'd0, 8'd255, 8'd255, 8'd255, 8'd255));
      queue_word(curve_word(16'd1, 8'd128, 8'd128, 8'd128, 8'd128));
      queue_word(curve_word(16'h8000, 8'd128, 8'd128, 8'd128, 8'd128));
      queue_word(curve_word(16'h4000, 8'd64, 8'd26, 8'd64, 8'd255));
      queue_word(curve_word(16'hC000, 8'd107, 8'd0, 8'd255, 8'd255));
      queue_word(curve_word(16'h2000, 8'd0, 8'd0, 8'd148, 8'd255));
      queue_word(curve_word(16'h8000, 8'd255, 8'd0, 8'd0, 8'd255));
      queue_word(curve_word(16'h8000, 8'd0, 8'd255, 8'd255, 8'd0));
      queue_word(curve_word(16'h5555, 8'hAA, 8'h55, 8'hAA, 8'h55));
      queue_word(curve_word(16'hAAAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
      queue_word(curve_word(16'hFFFE, 8'd255, 8'd0, 8'd255, 8'd0));
      queue_word(curve_word(16'h0001, 8'd0, 8'd255, 8'd0, 8'd255));
      queue_word(curve_word(16'h7FFF, 8'd1, 8'd254, 8'd254, 8'd1));
      wait_drained();

      foreach (tol_plan[k]) begin
         write_tolerance(tol_plan[k]);
         sender_steady = (k == 4) || ($urandom_range(0, 3) == 0);
         receiver_steady = (k != 4) && ($urandom_range(0, 3) == 0);
         if (k == 2) begin
            queue_word(curve_word(16'h8000, 8'd128, 8'd128, 8'd128, 8'd128));
            queue_word(curve_word(16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
         end
         repeat (PHASE_WORDS) queue_word(random_curve_word());
         if (k == 4) hold_requests++;
         wait_drained();
      end

      write_tolerance(TOLERANCE_RESET);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && eased_results_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
